// ===== hw/rtl/lrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED rainbow fill package
// Shared transaction types, register indexes, effect codes and wheel constants.
// ----------------------------------------------------------------------------
package lrf_pkg;

   localparam int unsigned HUE_W     = 11;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 8;

   localparam logic [HUE_W-1:0] WHEEL_STEPS = 11'd1530;
   localparam logic [HUE_W-1:0] SEG_LEN     = 11'd255;

   // effect modes
   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_RAINBOW = 2'd1;
   localparam logic [1:0] MODE_CONST   = 2'd2;
   localparam logic [1:0] MODE_PASS    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EFFECT_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HUE_SPEED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_SPACING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_RED   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_GREEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_BLUE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_ALPHA = 3'd6;

   // fill decision made by the front end
   localparam logic [1:0] FILL_PASS  = 2'd0;
   localparam logic [1:0] FILL_BLACK = 2'd1;
   localparam logic [1:0] FILL_WHEEL = 2'd2;
   localparam logic [1:0] FILL_CONST = 2'd3;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic [7:0] pixel_alpha;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      logic [1:0] effect_mode;
      logic [7:0] hue_speed;
      logic [3:0] led_spacing;
      logic [7:0] const_red;
      logic [7:0] const_green;
      logic [7:0] const_blue;
      logic [7:0] const_alpha;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       fill_class;
      logic [HUE_W-1:0] hue;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [7:0]       alpha;
   } fill_entry_type;

endpackage

// ===== hw/rtl/lrf_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED rainbow fill configuration registers
// Write-only register bank decoded from a plain index/data write port.
// ----------------------------------------------------------------------------
module lrf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [lrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lrf_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output lrf_pkg::cfg_type               cfg
);
   import lrf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EFFECT_MODE: cfg_in.effect_mode = csr_wdata[1:0];
            CSR_HUE_SPEED:   cfg_in.hue_speed   = csr_wdata;
            CSR_LED_SPACING: cfg_in.led_spacing = csr_wdata[3:0];
            CSR_CONST_RED:   cfg_in.const_red   = csr_wdata;
            CSR_CONST_GREEN: cfg_in.const_green = csr_wdata;
            CSR_CONST_BLUE:  cfg_in.const_blue  = csr_wdata;
            CSR_CONST_ALPHA: cfg_in.const_alpha = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.effect_mode <= MODE_NONE;
         cfg_ff.hue_speed   <= 8'd0;
         cfg_ff.led_spacing <= 4'd8;
         cfg_ff.const_red   <= 8'd0;
         cfg_ff.const_green <= 8'd0;
         cfg_ff.const_blue  <= 8'd0;
         cfg_ff.const_alpha <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/lrf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED rainbow fill front end
// Tracks the hue base and pixel offset, classifies each pixel and forms its
// wheel position.
// ----------------------------------------------------------------------------
module lrf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  lrf_pkg::cfg_type        cfg,
   input  lrf_pkg::req_type        req_data,
   input  logic                    accept,
   output lrf_pkg::fill_entry_type entry
);
   import lrf_pkg::*;

   logic [HUE_W-1:0] hue_base_ff, hue_base_in;
   logic [HUE_W-1:0] offset_ff, offset_in;
   logic [HUE_W-1:0] offset_cur;
   logic [HUE_W-1:0] base_cur;
   logic [HUE_W:0]   base_sum;
   logic [HUE_W:0]   hue_sum;
   logic [HUE_W:0]   off_sum;
   logic [HUE_W-1:0] hue;
   logic [1:0]       fill_class;

   always_comb begin
      offset_cur = req_data.frame_start ? '0 : offset_ff;

      // advance the base on a frame start in rainbow mode
      base_sum = {1'b0, hue_base_ff} + {{(HUE_W-7){1'b0}}, cfg.hue_speed};
      if (req_data.frame_start && (cfg.effect_mode == MODE_RAINBOW)) begin
         base_cur = (base_sum >= {1'b0, WHEEL_STEPS}) ?
                    HUE_W'(base_sum - {1'b0, WHEEL_STEPS}) : HUE_W'(base_sum);
      end else begin
         base_cur = hue_base_ff;
      end

      hue_sum = {1'b0, base_cur} + {1'b0, offset_cur};
      hue = (hue_sum >= {1'b0, WHEEL_STEPS}) ?
            HUE_W'(hue_sum - {1'b0, WHEEL_STEPS}) : HUE_W'(hue_sum);

      off_sum = {1'b0, offset_cur} + {{(HUE_W-3){1'b0}}, cfg.led_spacing};
      offset_in = (off_sum >= {1'b0, WHEEL_STEPS}) ?
                  HUE_W'(off_sum - {1'b0, WHEEL_STEPS}) : HUE_W'(off_sum);

      hue_base_in = base_cur;

      if (req_data.pixel_alpha != 8'd0) begin
         fill_class = FILL_PASS;
      end else begin
         unique case (cfg.effect_mode)
            MODE_NONE:    fill_class = FILL_BLACK;
            MODE_RAINBOW: fill_class = FILL_WHEEL;
            MODE_CONST:   fill_class = FILL_CONST;
            MODE_PASS:    fill_class = FILL_PASS;
            default:      fill_class = FILL_PASS;
         endcase
      end

      entry.fill_class = fill_class;
      entry.hue        = hue;
      entry.red        = req_data.pixel_red;
      entry.green      = req_data.pixel_green;
      entry.blue       = req_data.pixel_blue;
      entry.alpha      = req_data.pixel_alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_base_ff <= '0;
         offset_ff   <= '0;
      end else if (accept) begin
         hue_base_ff <= hue_base_in;
         offset_ff   <= offset_in;
      end
   end

`ifndef SYNTHESIS
   a_base_range: assert property (@(posedge clock) disable iff (reset)
      hue_base_ff < WHEEL_STEPS)
      else $error("hue base left the wheel");
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      offset_ff < WHEEL_STEPS)
      else $error("pixel offset left the wheel");
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      accept |-> (entry.hue < WHEEL_STEPS))
      else $error("wheel position out of range");
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.frame_start) |=>
         (offset_ff == (({7'd0, $past(cfg.led_spacing)} >= WHEEL_STEPS) ?
                        11'd0 : {7'd0, $past(cfg.led_spacing)})))
      else $error("offset not restarted on frame start");
`endif

endmodule

// ===== hw/rtl/lrf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED rainbow fill decoupling queue
// Small FIFO of classified pixels between the front and back ends.
// ----------------------------------------------------------------------------
module lrf_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lrf_pkg::fill_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output lrf_pkg::fill_entry_type head_entry,
   output logic                    empty
);
   import lrf_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   fill_entry_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("transaction lost on push");
`endif

endmodule

// ===== hw/rtl/lrf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED rainbow fill back end
// Turns a classified pixel into its final color and holds it for the receiver.
// ----------------------------------------------------------------------------
module lrf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  lrf_pkg::cfg_type        cfg,
   input  lrf_pkg::fill_entry_type head_entry,
   input  logic                    queue_empty,
   output logic                    queue_pop,
   output lrf_pkg::rsp_type        rsp_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop
);
   import lrf_pkg::*;

   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;
   logic [HUE_W-1:0] frac_wide;
   logic [7:0]       frac;
   logic [7:0]       wheel_r, wheel_g, wheel_b;

   // take the next transaction when the output slot is free or draining
   assign queue_pop = !queue_empty && (!out_valid_ff || rsp_pop);

   always_comb begin
      // segment select by compare instead of dividing by the segment length
      wheel_r = 8'd255;
      wheel_g = 8'd0;
      wheel_b = 8'd0;
      frac_wide = head_entry.hue;
      if (head_entry.hue < SEG_LEN) begin
         frac_wide = head_entry.hue;
      end else if (head_entry.hue < 11'd510) begin
         frac_wide = head_entry.hue - 11'd255;
      end else if (head_entry.hue < 11'd765) begin
         frac_wide = head_entry.hue - 11'd510;
      end else if (head_entry.hue < 11'd1020) begin
         frac_wide = head_entry.hue - 11'd765;
      end else if (head_entry.hue < 11'd1275) begin
         frac_wide = head_entry.hue - 11'd1020;
      end else begin
         frac_wide = head_entry.hue - 11'd1275;
      end
      frac = frac_wide[7:0];

      if (head_entry.hue < SEG_LEN) begin
         wheel_r = 8'd255;        wheel_g = frac;          wheel_b = 8'd0;
      end else if (head_entry.hue < 11'd510) begin
         wheel_r = 8'd255 - frac; wheel_g = 8'd255;        wheel_b = 8'd0;
      end else if (head_entry.hue < 11'd765) begin
         wheel_r = 8'd0;          wheel_g = 8'd255;        wheel_b = frac;
      end else if (head_entry.hue < 11'd1020) begin
         wheel_r = 8'd0;          wheel_g = 8'd255 - frac; wheel_b = 8'd255;
      end else if (head_entry.hue < 11'd1275) begin
         wheel_r = frac;          wheel_g = 8'd0;          wheel_b = 8'd255;
      end else begin
         wheel_r = 8'd255;        wheel_g = 8'd0;          wheel_b = 8'd255 - frac;
      end
   end

   always_comb begin
      out_data_in.out_red   = head_entry.red;
      out_data_in.out_green = head_entry.green;
      out_data_in.out_blue  = head_entry.blue;
      out_data_in.out_alpha = head_entry.alpha;
      unique case (head_entry.fill_class)
         FILL_PASS: begin
         end
         FILL_BLACK: begin
            out_data_in.out_red   = 8'd0;
            out_data_in.out_green = 8'd0;
            out_data_in.out_blue  = 8'd0;
         end
         FILL_WHEEL: begin
            out_data_in.out_red   = wheel_r;
            out_data_in.out_green = wheel_g;
            out_data_in.out_blue  = wheel_b;
         end
         FILL_CONST: begin
            out_data_in.out_red   = cfg.const_red;
            out_data_in.out_green = cfg.const_green;
            out_data_in.out_blue  = cfg.const_blue;
            out_data_in.out_alpha = cfg.const_alpha;
         end
         default: begin
         end
      endcase

      if (queue_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_data  = out_data_ff;
   assign rsp_empty = !out_valid_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("held result overwritten");
   a_wheel_alpha: assert property (@(posedge clock) disable iff (reset)
      (queue_pop && head_entry.fill_class == FILL_WHEEL) |->
         (head_entry.alpha == 8'd0))
      else $error("wheel fill on opaque pixel");
   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      (queue_pop && head_entry.fill_class == FILL_WHEEL) |->
         (head_entry.hue < WHEEL_STEPS))
      else $error("wheel position out of range");
`endif

endmodule

// ===== hw/rtl/led_rainbow_fill_effect_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED rainbow fill effect core
// Fills transparent LED pixels with black, a constant color or a hue wheel,
// or passes them through unchanged.
// Usage:
//   Pixels enter on req_data with req_push while req_full is low; each
//   transaction yields exactly one colored pixel on rsp_data, taken with
//   rsp_pop while rsp_empty is low. Mark the first pixel of each frame with
//   frame_start to restart the LED offset and, in rainbow mode, step the
//   hue base by hue_speed.
//   An accepted pixel is stored in the queue, then in the output register;
//   one pixel per cycle is sustained while the receiver pops. The front end
//   does the hue arithmetic (three 11-bit add and wrap steps) in the accept
//   cycle, the back end maps the wheel position to a color for that register.
//   A queue of QUEUE_DEPTH entries sits between front and back; when the
//   receiver stalls, the output register and then the queue fill, after
//   which req_full rises. No pixel is dropped.
//   Reset clears the hue base, offset and queue and loads register reset
//   values (spacing 8, everything else zero). The csr port writes one
//   register per cycle; write only while no transaction is in flight.
// ----------------------------------------------------------------------------
module led_rainbow_fill_effect_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  lrf_pkg::req_type              req_data,
   output logic                          req_full,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output lrf_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [lrf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lrf_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import lrf_pkg::*;

   cfg_type        cfg;
   fill_entry_type front_entry;
   fill_entry_type head_entry;
   logic           req_accept;
   logic           queue_empty;
   logic           queue_pop;

   assign req_accept = req_push && !req_full;

   lrf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   lrf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .accept   (req_accept),
      .entry    (front_entry)
   );

   lrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_entry (front_entry),
      .full       (req_full),
      .pop        (queue_pop),
      .head_entry (head_entry),
      .empty      (queue_empty)
   );

   lrf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head_entry  (head_entry),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .rsp_data    (rsp_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop)
   );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED rainbow fill effect testbench
// Streams pixel frames through the fill core under every effect mode and a
// range of register settings. A scoreboard tracks the hue base and LED
// offset, predicts each output pixel and checks the results in order while
// both the pixel source and the pixel sink stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import lrf_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   class fill_scoreboard;
      cfg_type settings;
      int      hue_base;
      int      hue_offset;
      rsp_type expected_pixels[$];
      int      failures;

      function new();
         settings             = '0;
         settings.led_spacing = 4'd8;
         hue_base             = 0;
         hue_offset           = 0;
         failures             = 0;
      endfunction

      function int wheel_add(int a, int b);
         int s;
         s = a + b;
         if (s >= int'(WHEEL_STEPS)) s -= int'(WHEEL_STEPS);
         return s;
      endfunction

      function rsp_type wheel_color(int h);
         int         seg;
         logic [7:0] f;
         rsp_type    c;
         seg = h / int'(SEG_LEN);
         f   = 8'(h % int'(SEG_LEN));
         c   = '0;
         case (seg)
            0: begin c.out_red = 8'hFF;     c.out_green = f;         c.out_blue = 8'h00; end
            1: begin c.out_red = 8'hFF - f; c.out_green = 8'hFF;     c.out_blue = 8'h00; end
            2: begin c.out_red = 8'h00;     c.out_green = 8'hFF;     c.out_blue = f; end
            3: begin c.out_red = 8'h00;     c.out_green = 8'hFF - f; c.out_blue = 8'hFF; end
            4: begin c.out_red = f;         c.out_green = 8'h00;     c.out_blue = 8'hFF; end
            default: begin
               c.out_red = 8'hFF; c.out_green = 8'h00; c.out_blue = 8'hFF - f;
            end
         endcase
         return c;
      endfunction

      function void note_pixel(req_type px);
         rsp_type res;
         if (px.frame_start) begin
            hue_offset = 0;
            if (settings.effect_mode == MODE_RAINBOW)
               hue_base = wheel_add(hue_base, int'(settings.hue_speed));
         end
         res = '{px.pixel_red, px.pixel_green, px.pixel_blue, px.pixel_alpha};
         if (px.pixel_alpha == 8'd0) begin
            case (settings.effect_mode)
               MODE_NONE:    res = '0;
               MODE_RAINBOW: res = wheel_color(wheel_add(hue_base, hue_offset));
               MODE_CONST:   res = '{settings.const_red, settings.const_green,
                                     settings.const_blue, settings.const_alpha};
               default: ;
            endcase
         end
         hue_offset = wheel_add(hue_offset, int'(settings.led_spacing));
         expected_pixels.push_back(res);
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type exp_px;
         if (expected_pixels.size() == 0) begin
            $error("unexpected output pixel %0h", got);
            failures++;
            return;
         end
         exp_px = expected_pixels.pop_front();
         if (got.out_red !== exp_px.out_red) begin
            $error("out_red: expected %0h, got %0h", exp_px.out_red, got.out_red);
            failures++;
         end
         if (got.out_green !== exp_px.out_green) begin
            $error("out_green: expected %0h, got %0h", exp_px.out_green, got.out_green);
            failures++;
         end
         if (got.out_blue !== exp_px.out_blue) begin
            $error("out_blue: expected %0h, got %0h", exp_px.out_blue, got.out_blue);
            failures++;
         end
         if (got.out_alpha !== exp_px.out_alpha) begin
            $error("out_alpha: expected %0h, got %0h", exp_px.out_alpha, got.out_alpha);
            failures++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   req_type              req_data;
   logic                 req_full;
   logic                 rsp_empty;
   logic                 rsp_pop;
   rsp_type              rsp_data;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   fill_scoreboard sb = new();
   bit             idle_on = 1'b1;
   bit             sender_gaps;
   int             cycles = 0;

   led_rainbow_fill_effect_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_data         (req_data),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Sample both handshakes with the values settled before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) sb.note_pixel(req_data);
         if (rsp_pop && !rsp_empty) sb.check_pixel(rsp_data);
      end
   end

   // Pixel sink: pop by default, stall in random bursts while idling is on.
   initial begin
      int stall_left;
      rsp_pop    = 1'b0;
      stall_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (idle_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 12);
         end
         @(posedge clock);
      end
   end

   function req_type make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [7:0] a, logic s);
      req_type px;
      px = '{r, g, b, a, s};
      return px;
   endfunction

   function cfg_type make_cfg(logic [1:0] mode, logic [7:0] speed, logic [3:0] spacing,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      cfg_type c;
      c = '{mode, speed, spacing, r, g, b, a};
      return c;
   endfunction

   task automatic send_pixel(req_type px);
      if (idle_on && sender_gaps && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Hold the source until every pixel has left, then let the pipe empty.
   task automatic settle();
      req_push <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      settle();
      write_reg(CSR_EFFECT_MODE, CSR_DAT_W'(c.effect_mode));
      write_reg(CSR_HUE_SPEED, c.hue_speed);
      write_reg(CSR_LED_SPACING, CSR_DAT_W'(c.led_spacing));
      write_reg(CSR_CONST_RED, c.const_red);
      write_reg(CSR_CONST_GREEN, c.const_green);
      write_reg(CSR_CONST_BLUE, c.const_blue);
      write_reg(CSR_CONST_ALPHA, c.const_alpha);
      csr_write_enable <= 1'b0;
      sb.settings = c;
   endtask

   task automatic send_frames(int count);
      int sent;
      int frame_len;
      logic [7:0] alpha;
      logic start;
      sent = 0;
      while (sent < count) begin
         frame_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 220)
                                                  : $urandom_range(1, 40);
         sender_gaps = $urandom_range(0, 2) != 0;
         for (int i = 0; i < frame_len && sent < count; i++) begin
            // Mostly clean frames; now and then a missing or stray frame start.
            start = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
            alpha = ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(1, 255));
            send_pixel(make_pixel(8'($urandom), 8'($urandom), 8'($urandom), alpha, start));
            sent++;
         end
      end
   endtask

   initial begin
      logic [1:0] phase_modes [8];
      cfg_type c;
      req_push         = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_EFFECT_MODE;
      csr_wdata        = '0;
      sender_gaps      = 1'b1;
      phase_modes = '{MODE_RAINBOW, MODE_NONE, MODE_RAINBOW, MODE_CONST,
                      MODE_PASS, MODE_RAINBOW, MODE_CONST, MODE_RAINBOW};
      @(posedge clock);
      while (reset) @(posedge clock);

      // Reset settings: black fill, opaque pixels pass.
      send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1));
      send_pixel(make_pixel(8'h5A, 8'hA5, 8'h3C, 8'hFF, 1'b0));
      send_pixel(make_pixel(8'h80, 8'h01, 8'hFE, 8'h01, 1'b0));

      // Fastest hue step and widest spacing walk the wheel quickly.
      apply_settings(make_cfg(MODE_RAINBOW, 8'hFF, 4'hF, 8'h00, 8'h00, 8'h00, 8'h00));
      send_pixel(make_pixel(8'h11, 8'h22, 8'h33, 8'h00, 1'b1));
      for (int i = 0; i < 8; i++) send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));
      send_pixel(make_pixel(8'hC3, 8'h3C, 8'h99, 8'hFF, 1'b0));
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));

      apply_settings(make_cfg(MODE_CONST, 8'h00, 4'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
      send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h7F, 1'b0));

      // Frame start outside rainbow mode must leave the base alone.
      apply_settings(make_cfg(MODE_PASS, 8'hFF, 4'h8, 8'h00, 8'h00, 8'h00, 8'h00));
      send_pixel(make_pixel(8'hAB, 8'hCD, 8'hEF, 8'h00, 1'b1));
      send_pixel(make_pixel(8'h01, 8'h02, 8'h03, 8'h00, 1'b0));

      apply_settings(make_cfg(MODE_RAINBOW, 8'h00, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));

      for (int p = 0; p < 8; p++) begin
         c = make_cfg(phase_modes[p], 8'($urandom), 4'($urandom_range(0, 15)),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         case (p)
            0: begin c.hue_speed = 8'hFF; c.led_spacing = 4'hF; end
            2: begin c.hue_speed = 8'h00; c.led_spacing = 4'h8; end
            3: c = make_cfg(MODE_CONST, 8'h00, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00);
            5: begin c.hue_speed = 8'h01; c.led_spacing = 4'h1; end
            6: c = make_cfg(MODE_CONST, 8'hFF, 4'hF, 8'hFF, 8'h00, 8'hFF, 8'h00);
            default: ;
         endcase
         // The last stretch runs at full rate on both sides.
         if (p == 7) idle_on = 1'b0;
         apply_settings(c);
         send_frames(110);
      end

      settle();
      repeat (10) @(posedge clock);
      if (sb.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== led_rainbow_fill_effect_core.f =====
hw/rtl/lrf_pkg.sv
hw/rtl/lrf_csr.sv
hw/rtl/lrf_front.sv
hw/rtl/lrf_queue.sv
hw/rtl/lrf_back.sv
hw/rtl/led_rainbow_fill_effect_core.sv
sim/testbench.sv
